// ===== sv/arft_pkg.sv =====
// Shared types and codes for the address range fixup table.
// Request and status codes, the stored entry layout. No dependencies.
package arft_pkg;

    // Request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    // Field widths fixed by the interface
    localparam int ADDR_W   = 64;
    localparam int DOMAIN_W = 32;
    localparam int SLOT_W   = 6;
    localparam int LIVE_W   = 7;

    // One stored table entry
    typedef struct packed {
        logic [ADDR_W-1:0]   rng_start;
        logic [ADDR_W-1:0]   rng_end;
        logic [ADDR_W-1:0]   fixup;
        logic [DOMAIN_W-1:0] domain;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/arft_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module arft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/address_range_fixup_table.sv =====
// Address range fixup table: top level with request sequencer and entry RAM.
// Depends on arft_pkg and arft_ram.
//
// Append-only table of [start, end) ranges with a fixup address and domain id,
// held in one RAM of TABLE_DEPTH entries with a registered read port.
// One item is handled at a time. The sequencer captures an item in idle and
// answers it from the execute state when it is an insert, an unused request code
// or a read past the live count; a read at index waits in the read-wait state
// for the RAM data; a lookup moves to the scan state and reads one entry per cycle
// through the single RAM read port, lowest index first, until it hits or reaches
// the last live entry (an empty table answers a miss from the execute state).
// The result sits in an output register; the block takes the next item once
// the sequencer is back to idle, even while that result is still stalled.
// No clearing pass follows reset: only entries below the live count are read.
module address_range_fixup_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [63:0] range_start,
    input  logic [63:0] range_end,
    input  logic [63:0] fixup_addr,
    input  logic [31:0] domain_tag,
    input  logic [63:0] query_addr,
    input  logic [5:0]  entry_index,
    // Result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [63:0] found_fixup,
    output logic [31:0] found_domain,
    output logic [63:0] found_start,
    output logic [63:0] found_end,
    output logic [5:0]  found_slot,
    output logic [6:0]  live_count
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = CNT_W + arft_pkg::SLOT_W + 1;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_RDW  = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [IDX_W-1:0]                addr_reg, addr_next;

    // Captured request
    logic [1:0]                      req_reg;
    logic [arft_pkg::ADDR_W-1:0]     start_in_reg, end_in_reg, fixup_in_reg, query_reg;
    logic [arft_pkg::DOMAIN_W-1:0]   domain_in_reg;
    logic [arft_pkg::SLOT_W-1:0]     index_reg;

    // Output register
    logic                            out_valid_reg, out_valid_next;
    logic [1:0]                      status_reg, status_next;
    arft_pkg::entry_t                entry_out_reg, entry_out_next;
    logic [arft_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [arft_pkg::LIVE_W-1:0]     live_reg, live_next;

    // RAM interface
    logic                            wr_en;
    arft_pkg::entry_t                wr_entry;
    logic [arft_pkg::ENTRY_W-1:0]    rd_data;
    arft_pkg::entry_t                rd_entry;

    // Helpers
    logic                            out_free;
    logic                            hit;
    logic                            bad_range;
    logic                            scan_last;
    logic [CMP_W-1:0]                ix_ext, cnt_ext, slot_ext, live_ext;
    logic [IDX_W-1:0]                ix_addr;
    logic [IDX_W-1:0]                slot_src;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign rd_entry  = arft_pkg::entry_t'(rd_data);
    assign hit       = (query_reg >= rd_entry.rng_start) && (query_reg < rd_entry.rng_end);
    assign bad_range = (start_in_reg >= end_in_reg) || (fixup_in_reg == '0);
    assign scan_last = ((CNT_W'(addr_reg) + CNT_W'(1)) == count_reg);
    assign ix_ext    = CMP_W'(index_reg);
    assign cnt_ext   = CMP_W'(count_reg);
    assign ix_addr   = ix_ext[IDX_W-1:0];
    // insert reports the slot it fills, scan and read the slot they hold
    assign slot_src  = (state_reg == S_EXEC) ? count_reg[IDX_W-1:0] : addr_reg;
    assign slot_ext  = CMP_W'(slot_src);

    assign wr_entry.rng_start = start_in_reg;
    assign wr_entry.rng_end   = end_in_reg;
    assign wr_entry.fixup     = fixup_in_reg;
    assign wr_entry.domain    = domain_in_reg;

    // Sequencer and result formation
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        wr_en          = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        entry_out_next = entry_out_reg;
        slot_next      = slot_reg;
        live_next      = live_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (req_reg)
                    arft_pkg::REQ_INSERT:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            entry_out_next = '0;
                            slot_next      = '0;
                            state_next     = S_IDLE;
                            if (bad_range)
                            begin
                                status_next = arft_pkg::ST_BAD;
                            end
                            else if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = arft_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                                status_next = arft_pkg::ST_OK;
                                slot_next   = slot_ext[arft_pkg::SLOT_W-1:0];
                            end
                        end
                    end
                    arft_pkg::REQ_LOOKUP:
                    begin
                        if (count_reg != '0)
                        begin
                            addr_next  = '0;
                            state_next = S_SCAN;
                        end
                        else if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = arft_pkg::ST_MISS;
                            entry_out_next = '0;
                            slot_next      = '0;
                            state_next     = S_IDLE;
                        end
                    end
                    arft_pkg::REQ_READ:
                    begin
                        if (ix_ext < cnt_ext)
                        begin
                            addr_next  = ix_addr;
                            state_next = S_RDW;
                        end
                        else if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = arft_pkg::ST_MISS;
                            entry_out_next = '0;
                            slot_next      = '0;
                            state_next     = S_IDLE;
                        end
                    end
                    default:
                    begin
                        // unused request code: plain miss, no state change
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = arft_pkg::ST_MISS;
                            entry_out_next = '0;
                            slot_next      = '0;
                            state_next     = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                // rd_entry holds the entry at addr_reg
                if (hit)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = arft_pkg::ST_OK;
                        entry_out_next = rd_entry;
                        slot_next      = slot_ext[arft_pkg::SLOT_W-1:0];
                        state_next     = S_IDLE;
                    end
                end
                else if (scan_last)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = arft_pkg::ST_MISS;
                        entry_out_next = '0;
                        slot_next      = '0;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            S_RDW:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = arft_pkg::ST_OK;
                    entry_out_next = rd_entry;
                    slot_next      = slot_ext[arft_pkg::SLOT_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // live count after this request
        live_ext = CMP_W'(count_next);
        if (out_valid_next && !(out_valid_reg && out_stall))
        begin
            live_next = live_ext[arft_pkg::LIVE_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request capture and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            req_reg       <= req_type;
            start_in_reg  <= range_start;
            end_in_reg    <= range_end;
            fixup_in_reg  <= fixup_addr;
            domain_in_reg <= domain_tag;
            query_reg     <= query_addr;
            index_reg     <= entry_index;
        end
        status_reg    <= status_next;
        entry_out_reg <= entry_out_next;
        slot_reg      <= slot_next;
        live_reg      <= live_next;
    end

    // Entry storage
    arft_ram #(
        .WIDTH (arft_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_addr (addr_next),
        .rd_data (rd_data)
    );

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_fixup  = entry_out_reg.fixup;
    assign found_domain = entry_out_reg.domain;
    assign found_start  = entry_out_reg.rng_start;
    assign found_end    = entry_out_reg.rng_end;
    assign found_slot   = slot_reg;
    assign live_count   = live_reg;

    // Live count never exceeds the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("live count above table depth");

    // Every RAM write adds exactly one entry
    a_write_counts: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance live count");

    // Scan and indexed read stay within the live entries
    a_addr_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_RDW) |-> (CNT_W'(addr_reg) < count_reg))
        else $error("RAM read beyond live entries");

    // A result is produced only when leaving a busy state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) != S_IDLE && state_reg == S_IDLE))
        else $error("result without a request in progress");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for address_range_fixup_table: a directed table, then random traffic.
// Each result is checked against a listed value or a model table kept here.
// Depends on arft_pkg and the RTL of address_range_fixup_table.
module tb;

    // Request code 3 is not assigned; the block answers it as a miss
    localparam logic [1:0]  REQ_RSVD     = 2'd3;
    localparam int          TABLE_DEPTH  = 64;
    localparam int          N_RANDOM     = 527;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [63:0] ADDR_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CLUSTER_BASE = 64'h0000_7F00_0000_0000;

    typedef struct packed {
        logic [1:0]                    kind;
        logic [arft_pkg::ADDR_W-1:0]   rng_start;
        logic [arft_pkg::ADDR_W-1:0]   rng_end;
        logic [arft_pkg::ADDR_W-1:0]   fixup;
        logic [arft_pkg::DOMAIN_W-1:0] domain;
        logic [arft_pkg::ADDR_W-1:0]   query;
        logic [arft_pkg::SLOT_W-1:0]   index;
    } fixup_req_t;

    typedef struct packed {
        logic [1:0]                    status;
        logic [arft_pkg::ADDR_W-1:0]   fixup;
        logic [arft_pkg::DOMAIN_W-1:0] domain;
        logic [arft_pkg::ADDR_W-1:0]   rng_start;
        logic [arft_pkg::ADDR_W-1:0]   rng_end;
        logic [arft_pkg::SLOT_W-1:0]   slot;
        logic [arft_pkg::LIVE_W-1:0]   live;
    } fixup_res_t;

    typedef struct packed {
        fixup_req_t req;
        logic       typed;
        fixup_res_t res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = '0;
    logic [63:0] range_start = '0;
    logic [63:0] range_end = '0;
    logic [63:0] fixup_addr = '0;
    logic [31:0] domain_tag = '0;
    logic [63:0] query_addr = '0;
    logic [5:0]  entry_index = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [63:0] found_fixup;
    logic [31:0] found_domain;
    logic [63:0] found_start;
    logic [63:0] found_end;
    logic [5:0]  found_slot;
    logic [6:0]  live_count;

    // Model copy of the table
    logic [arft_pkg::ADDR_W-1:0]   tbl_start [TABLE_DEPTH];
    logic [arft_pkg::ADDR_W-1:0]   tbl_end [TABLE_DEPTH];
    logic [arft_pkg::ADDR_W-1:0]   tbl_fixup [TABLE_DEPTH];
    logic [arft_pkg::DOMAIN_W-1:0] tbl_domain [TABLE_DEPTH];
    logic [arft_pkg::LIVE_W-1:0]   tbl_count = '0;

    fixup_res_t pending_results[$];
    stim_row_t  directed_rows[$];
    int         err_count = 0;
    int         n_offered = 0;
    int         next_gap = 0;
    int         tally [4][4];

    always #1 clk = ~clk;

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    address_range_fixup_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .range_start  (range_start),
        .range_end    (range_end),
        .fixup_addr   (fixup_addr),
        .domain_tag   (domain_tag),
        .query_addr   (query_addr),
        .entry_index  (entry_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .found_fixup  (found_fixup),
        .found_domain (found_domain),
        .found_start  (found_start),
        .found_end    (found_end),
        .found_slot   (found_slot),
        .live_count   (live_count)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Wait before an item: random, with every fourth stretch of 50 items back to back
    function automatic int draw_wait(input int seq);
        return ((seq / 50) % 4 == 3) ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic fixup_req_t mk_req(input logic [1:0] kind, input logic [63:0] s,
                                          input logic [63:0] e, input logic [63:0] f,
                                          input logic [31:0] d, input logic [63:0] q,
                                          input logic [5:0] ix);
        fixup_req_t r;
        r.kind = kind;
        r.rng_start = s;
        r.rng_end = e;
        r.fixup = f;
        r.domain = d;
        r.query = q;
        r.index = ix;
        return r;
    endfunction

    function automatic fixup_res_t mk_res(input logic [1:0] st, input logic [63:0] f,
                                          input logic [31:0] d, input logic [63:0] s,
                                          input logic [63:0] e, input logic [5:0] slot,
                                          input logic [6:0] live);
        fixup_res_t r;
        r.status = st;
        r.fixup = f;
        r.domain = d;
        r.rng_start = s;
        r.rng_end = e;
        r.slot = slot;
        r.live = live;
        return r;
    endfunction

    task automatic add_row(input fixup_req_t req, input logic typed, input fixup_res_t res);
        stim_row_t row;
        row.req = req;
        row.typed = typed;
        row.res = res;
        directed_rows.push_back(row);
    endtask

    function automatic fixup_res_t entry_result(input int i);
        fixup_res_t r;
        r.status = arft_pkg::ST_OK;
        r.fixup = tbl_fixup[i];
        r.domain = tbl_domain[i];
        r.rng_start = tbl_start[i];
        r.rng_end = tbl_end[i];
        r.slot = i[5:0];
        r.live = '0;
        return r;
    endfunction

    // Apply one accepted request to the model table and return the result it gives
    function automatic fixup_res_t apply_request(input fixup_req_t r);
        fixup_res_t res;
        logic       hit;
        res = '0;
        res.status = arft_pkg::ST_MISS;
        hit = 1'b0;
        case (r.kind)
            arft_pkg::REQ_INSERT:
            begin
                if (r.rng_start >= r.rng_end || r.fixup == '0)
                    res.status = arft_pkg::ST_BAD;
                else if (tbl_count >= TABLE_DEPTH)
                    res.status = arft_pkg::ST_FULL;
                else
                begin
                    tbl_start[tbl_count] = r.rng_start;
                    tbl_end[tbl_count] = r.rng_end;
                    tbl_fixup[tbl_count] = r.fixup;
                    tbl_domain[tbl_count] = r.domain;
                    res.status = arft_pkg::ST_OK;
                    res.slot = tbl_count[5:0];
                    tbl_count = tbl_count + 7'd1;
                end
            end
            arft_pkg::REQ_LOOKUP:
            begin
                // lowest index wins
                for (int i = 0; i < tbl_count && !hit; i++)
                begin
                    if (r.query >= tbl_start[i] && r.query < tbl_end[i])
                    begin
                        res = entry_result(i);
                        hit = 1'b1;
                    end
                end
            end
            arft_pkg::REQ_READ:
            begin
                if (r.index < tbl_count)
                    res = entry_result(r.index);
            end
            default:
            begin
            end
        endcase
        res.live = tbl_count;
        tally[r.kind][res.status]++;
        return res;
    endfunction

    // Random request shaped by the current table contents
    function automatic fixup_req_t make_random_request();
        fixup_req_t  r;
        logic [63:0] span;
        int          sel;
        int          i;
        // unused fields carry noise
        r.kind = arft_pkg::REQ_INSERT;
        r.rng_start = rand64();
        r.rng_end = rand64();
        r.fixup = rand64();
        r.domain = $urandom;
        r.query = rand64();
        r.index = 6'($urandom_range(0, 63));
        sel = $urandom_range(0, 99);
        if (sel < 2)
            r.kind = REQ_RSVD;
        else if (sel < ((tbl_count >= TABLE_DEPTH) ? 14 : 37))
        begin
            r.kind = arft_pkg::REQ_INSERT;
            if ($urandom_range(0, 2) != 0)
            begin
                // small ranges packed close together, so they overlap
                r.rng_start = CLUSTER_BASE + $urandom_range(0, 16'hFFFF);
                r.rng_end = r.rng_start + 64'd1 + $urandom_range(0, 12'h7FF);
            end
            else
            begin
                if (r.rng_start == ADDR_MAX)
                    r.rng_start = ADDR_MAX - 64'd1;
                span = ADDR_MAX - r.rng_start;
                r.rng_end = r.rng_start + 64'd1 + (rand64() % span);
            end
            if (r.fixup == '0)
                r.fixup = 64'd1;
            sel = $urandom_range(0, 9);
            if (sel == 0)
                r.domain = '0;
            else if (sel == 1)
                r.domain = '1;
            // a fifth of the inserts are altered, most of them into broken ones
            sel = $urandom_range(0, 19);
            if (sel == 0)
                r.rng_end = r.rng_start;
            else if (sel == 1)
                {r.rng_start, r.rng_end} = {r.rng_end, r.rng_start};
            else if (sel == 2)
                r.fixup = '0;
            else if (sel == 3)
            begin
                r.rng_start = rand64();
                r.rng_end = rand64();
            end
        end
        else if (sel < 70)
        begin
            r.kind = arft_pkg::REQ_LOOKUP;
            if (tbl_count != 0)
            begin
                i = $urandom_range(0, tbl_count - 1);
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    r.query = tbl_start[i] + (rand64() % (tbl_end[i] - tbl_start[i]));
                else if (sel == 6)
                    r.query = tbl_end[i];
                else if (sel == 7)
                    r.query = tbl_start[i] - 64'd1;
            end
        end
        else
        begin
            r.kind = arft_pkg::REQ_READ;
            if (tbl_count != 0 && $urandom_range(0, 3) != 0)
                r.index = 6'($urandom_range(0, tbl_count - 1));
        end
        return r;
    endfunction

    // Offer one item, wait for it to be taken, log its expected result
    task automatic offer(input stim_row_t row);
        fixup_res_t want;
        repeat (next_gap) @(posedge clk);
        in_valid <= 1'b1;
        req_type <= row.req.kind;
        range_start <= row.req.rng_start;
        range_end <= row.req.rng_end;
        fixup_addr <= row.req.fixup;
        domain_tag <= row.req.domain;
        query_addr <= row.req.query;
        entry_index <= row.req.index;
        do @(posedge clk); while (in_stall);
        want = apply_request(row.req);
        if (row.typed)
            want = row.res;
        pending_results.push_back(want);
        n_offered++;
        next_gap = draw_wait(n_offered);
        if (next_gap != 0)
            in_valid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic check_result(input fixup_res_t got);
        fixup_res_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: result with nothing expected: status %0d slot %0d live %0d",
                     $time, got.status, got.slot, got.live);
            err_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("found_fixup", want.fixup, got.fixup);
            compare_field("found_domain", want.domain, got.domain);
            compare_field("found_start", want.rng_start, got.rng_start);
            compare_field("found_end", want.rng_end, got.rng_end);
            compare_field("found_slot", want.slot, got.slot);
            compare_field("live_count", want.live, got.live);
        end
    endtask

    // Result side: random stalls, two long hold-offs to back the block up
    initial
    begin
        fixup_res_t got;
        int         hold;
        int         n_taken;
        hold = 0;
        n_taken = 0;
        forever
        begin
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got = mk_res(status, found_fixup, found_domain, found_start, found_end,
                         found_slot, live_count);
            check_result(got);
            n_taken++;
            if (n_taken == 120 || n_taken == 380)
                hold = HOLD_CYCLES;
            else
                hold = draw_wait(n_taken);
        end
    end

    // Request side: directed table, random traffic, drain, verdict
    initial
    begin
        stim_row_t row;
        int        n_random;
        // empty table
        add_row(mk_req(arft_pkg::REQ_LOOKUP, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_res(arft_pkg::ST_MISS, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(arft_pkg::REQ_READ, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_res(arft_pkg::ST_MISS, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(arft_pkg::REQ_READ, 0, 0, 0, 0, 0, 63), 1'b1,
                mk_res(arft_pkg::ST_MISS, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(REQ_RSVD, 0, ADDR_MAX, ADDR_MAX, '1, ADDR_MAX, 63), 1'b1,
                mk_res(arft_pkg::ST_MISS, 0, 0, 0, 0, 0, 0));
        // malformed inserts: empty range, reversed range, zero fixup
        add_row(mk_req(arft_pkg::REQ_INSERT, 64'h1000, 64'h1000, 1, 0, 0, 0), 1'b1,
                mk_res(arft_pkg::ST_BAD, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(arft_pkg::REQ_INSERT, ADDR_MAX, 0, ADDR_MAX, 0, 0, 0), 1'b1,
                mk_res(arft_pkg::ST_BAD, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(arft_pkg::REQ_INSERT, 0, ADDR_MAX, 0, '1, 0, 0), 1'b1,
                mk_res(arft_pkg::ST_BAD, 0, 0, 0, 0, 0, 0));
        // entries at both ends of the address space
        add_row(mk_req(arft_pkg::REQ_INSERT, 0, 1, ADDR_MAX, 0, 0, 0), 1'b1,
                mk_res(arft_pkg::ST_OK, 0, 0, 0, 0, 0, 1));
        add_row(mk_req(arft_pkg::REQ_INSERT, ADDR_MAX - 64'd1, ADDR_MAX, 1, '1, 0, 0), 1'b1,
                mk_res(arft_pkg::ST_OK, 0, 0, 0, 0, 1, 2));
        add_row(mk_req(arft_pkg::REQ_LOOKUP, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_res(arft_pkg::ST_OK, ADDR_MAX, 0, 0, 1, 0, 2));
        add_row(mk_req(arft_pkg::REQ_LOOKUP, 0, 0, 0, 0, 1, 0), 1'b1,
                mk_res(arft_pkg::ST_MISS, 0, 0, 0, 0, 0, 2));
        add_row(mk_req(arft_pkg::REQ_LOOKUP, 0, 0, 0, 0, ADDR_MAX, 0), 1'b1,
                mk_res(arft_pkg::ST_MISS, 0, 0, 0, 0, 0, 2));
        add_row(mk_req(arft_pkg::REQ_LOOKUP, 0, 0, 0, 0, ADDR_MAX - 64'd1, 0), 1'b1,
                mk_res(arft_pkg::ST_OK, 1, '1, ADDR_MAX - 64'd1, ADDR_MAX, 1, 2));
        add_row(mk_req(arft_pkg::REQ_READ, 0, 0, 0, 0, 0, 1), 1'b1,
                mk_res(arft_pkg::ST_OK, 1, '1, ADDR_MAX - 64'd1, ADDR_MAX, 1, 2));
        add_row(mk_req(arft_pkg::REQ_READ, 0, 0, 0, 0, 0, 2), 1'b1,
                mk_res(arft_pkg::ST_MISS, 0, 0, 0, 0, 0, 2));
        add_row(mk_req(arft_pkg::REQ_READ, 0, 0, 0, 0, 0, 63), 1'b1,
                mk_res(arft_pkg::ST_MISS, 0, 0, 0, 0, 0, 2));
        // overlapping ranges: first match by index
        add_row(mk_req(arft_pkg::REQ_INSERT, 64'h1000, 64'h2000, 64'hAAAA_AAAA_AAAA_AAAA,
                       32'h5555_5555, 0, 0), 1'b0, '0);
        add_row(mk_req(arft_pkg::REQ_INSERT, 64'h1800, 64'h3000, 64'h5555_5555_5555_5555,
                       32'hAAAA_AAAA, 0, 0), 1'b0, '0);
        add_row(mk_req(arft_pkg::REQ_LOOKUP, 0, 0, 0, 0, 64'h1900, 0), 1'b0, '0);
        add_row(mk_req(arft_pkg::REQ_LOOKUP, 0, 0, 0, 0, 64'h2000, 0), 1'b0, '0);
        add_row(mk_req(arft_pkg::REQ_LOOKUP, 0, 0, 0, 0, 64'h2FFF, 0), 1'b0, '0);
        add_row(mk_req(arft_pkg::REQ_READ, 0, 0, 0, 0, 0, 3), 1'b0, '0);
        add_row(mk_req(REQ_RSVD, 64'h1000, 64'h2000, 1, 1, 64'h1000, 0), 1'b0, '0);

        while (!rst_n) @(posedge clk);
        next_gap = draw_wait(0);
        foreach (directed_rows[k])
            offer(directed_rows[k]);

        n_random = 0;
        while (n_random < N_RANDOM)
        begin
            row.req = make_random_request();
            row.typed = 1'b0;
            row.res = '0;
            offer(row);
            if (row.req.kind != REQ_RSVD)
                n_random++;
        end
        if (next_gap == 0)
            in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d inserts stored, %0d malformed, %0d full, %0d reserved.",
                 n_offered, tally[arft_pkg::REQ_INSERT][arft_pkg::ST_OK],
                 tally[arft_pkg::REQ_INSERT][arft_pkg::ST_BAD],
                 tally[arft_pkg::REQ_INSERT][arft_pkg::ST_FULL],
                 tally[REQ_RSVD][arft_pkg::ST_MISS]);
        $display("Lookups %0d hit / %0d missed; reads %0d ok / %0d out of range; %0d held.",
                 tally[arft_pkg::REQ_LOOKUP][arft_pkg::ST_OK],
                 tally[arft_pkg::REQ_LOOKUP][arft_pkg::ST_MISS],
                 tally[arft_pkg::REQ_READ][arft_pkg::ST_OK],
                 tally[arft_pkg::REQ_READ][arft_pkg::ST_MISS], tbl_count);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
